// ===== sv/atct_pkg.sv =====
// Shared types and constants of the animation track clock table.
package atct_pkg;

  // Op codes carried on the input tuser field
  localparam logic [3:0] OP_TICK   = 4'd0;
  localparam logic [3:0] OP_PLAY   = 4'd1;
  localparam logic [3:0] OP_STOP   = 4'd2;
  localparam logic [3:0] OP_PAUSE  = 4'd3;
  localparam logic [3:0] OP_RESUME = 4'd4;
  localparam logic [3:0] OP_SEEK   = 4'd5;
  localparam logic [3:0] OP_LOOP   = 4'd6;
  localparam logic [3:0] OP_SPEED  = 4'd7;
  localparam logic [3:0] OP_GSPEED = 4'd8;
  localparam logic [3:0] OP_DUR    = 4'd9;
  localparam logic [3:0] OP_RESET  = 4'd10;

  localparam int DIVW = 33;                 // dividend magnitude width
  localparam int DURW = 31;                 // duration width
  localparam logic [5:0] DIV_STEPS = 6'd33; // one quotient bit a cycle
  localparam logic signed [15:0] SPEED_ONE = 16'sd256;
  localparam logic signed [31:0] TIME_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] TIME_MIN  = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_T_LOAD,
    S_T_MUL1,
    S_T_MUL2,
    S_T_SUM,
    S_T_DIV,
    S_T_WB,
    S_SEEK_DIV,
    S_RESP
  } state_t;

  typedef struct packed {
    logic cap;
    logic apply;
    logic walk;
    logic idx_inc;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_start;
    logic tick_wb;
    logic seek_wb;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic seek_div;
    logic playing;
    logic loop_div;
    logic idx_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/atct_div.sv =====
// Iterative restoring remainder unit, one bit a cycle.
module atct_div
  import atct_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DIVW-1:0] dividend,
  input  logic [DURW-1:0] divisor,
  output logic            busy,
  output logic            done,
  output logic [DURW-1:0] rem
);

  logic [5:0]      cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DIVW-1:0] num_r, num_nxt;
  logic [DURW-1:0] rem_r, rem_nxt;
  logic [DURW:0]   trial;
  logic [DURW:0]   diff;

  assign trial = {rem_r, num_r[DIVW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      cnt_nxt  = DIV_STEPS;
      busy_nxt = 1'b1;
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, divisor}) ? diff[DURW-1:0] : trial[DURW-1:0];
      num_nxt = {num_r[DIVW-2:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== sv/atct_dp.sv =====
// Datapath: track tables, tick multipliers, remainder unit and result register.
module atct_dp
  import atct_pkg::*;
#(
  parameter int TRACKS = 16
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  output status_t      sts,
  input  logic [3:0]   in_op,
  input  logic [103:0] in_data,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [71:0]  out_data
);

  localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

  logic signed [31:0] time_tab  [TRACKS];
  logic signed [15:0] speed_tab [TRACKS];
  logic [DURW-1:0]    dur_tab   [TRACKS];
  logic [TRACKS-1:0]  play_r;
  logic [TRACKS-1:0]  loop_r;
  logic signed [15:0] gspeed_r;

  logic [3:0]         op_r;
  logic [3:0]         trk_r;
  logic [19:0]        dt_r;
  logic signed [31:0] seek_r;
  logic signed [15:0] spd_r;
  logic [DURW-1:0]    dur_r;
  logic               lf_r;
  logic [TW-1:0]      idx_r;
  logic [15:0]        ended_r;
  logic [35:0]        mul1_r;
  logic [51:0]        mul2_r;
  logic               neg_r;
  logic signed [32:0] sum_r;
  logic [65:0]        res_r;
  logic               out_valid_r;

  logic               ok;
  logic [TW-1:0]      trk_idx;
  logic [TW-1:0]      rd;
  logic signed [31:0] rd_time;
  logic signed [15:0] rd_speed;
  logic [DURW-1:0]    rd_dur;
  logic [15:0]        smag;
  logic [15:0]        gmag;
  logic [35:0]        mag;
  logic signed [31:0] step;
  logic               seek_gt;
  logic               seek_neg;
  logic [DIVW-1:0]    dividend;
  logic               div_busy;
  logic               div_done;
  logic [DURW-1:0]    rem;
  logic signed [31:0] tick_time;
  logic               tick_end;
  logic signed [31:0] seek_time;

  assign ok       = 32'(trk_r) < TRACKS;
  assign trk_idx  = TW'(trk_r);
  assign rd       = cmd.walk ? idx_r : trk_idx;
  assign rd_time  = time_tab[rd];
  assign rd_speed = speed_tab[rd];
  assign rd_dur   = dur_tab[rd];

  assign smag = rd_speed[15] ? 16'(16'd0 - rd_speed) : rd_speed;
  assign gmag = gspeed_r[15] ? 16'(16'd0 - gspeed_r) : gspeed_r;

  // Saturate the truncated magnitude of dt*speed*global
  assign mag = mul2_r[51:16];
  always_comb begin
    if (!neg_r) begin
      step = (mag > 36'h0_7FFF_FFFF) ? TIME_MAX : $signed(mag[31:0]);
    end else begin
      step = (mag >= 36'h0_8000_0000) ? TIME_MIN : $signed(32'd0 - mag[31:0]);
    end
  end

  assign seek_neg = seek_r[31];
  assign seek_gt  = !seek_r[31] && (seek_r[30:0] > rd_dur);

  always_comb begin
    if (op_r == OP_TICK) begin
      dividend = sum_r[32] ? DIVW'(33'd0 - sum_r) : sum_r;
    end else if (seek_neg) begin
      dividend = DIVW'(33'd0 - {seek_r[31], seek_r});
    end else begin
      dividend = DIVW'({1'b0, seek_r} - 33'd1);
    end
  end

  atct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (rd_dur),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (rem)
  );

  // Tick write-back value for the walked track
  always_comb begin
    tick_end  = 1'b0;
    tick_time = sum_r[31:0];
    if (loop_r[idx_r]) begin
      if (rd_dur == '0) begin
        tick_time = '0;
      end else begin
        tick_time = sum_r[32] ? $signed(32'd0 - {1'b0, rem}) : $signed({1'b0, rem});
      end
    end else if (sum_r[32] || (sum_r > $signed({2'b00, rd_dur}))) begin
      tick_time = '0;
      tick_end  = 1'b1;
    end
  end

  always_comb begin
    if (seek_gt) begin
      seek_time = $signed({1'b0, rem} + 32'd1);
    end else begin
      seek_time = (rem == '0) ? 32'sd0 : $signed({1'b0, rd_dur - rem});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TRACKS; i++) begin
        time_tab[i]  <= '0;
        speed_tab[i] <= SPEED_ONE;
        dur_tab[i]   <= '0;
      end
      play_r   <= '0;
      loop_r   <= '0;
      gspeed_r <= SPEED_ONE;
    end else begin
      if (cmd.apply) begin
        case (op_r)
          OP_PLAY: if (ok) begin
            play_r[trk_idx]   <= 1'b1;
            time_tab[trk_idx] <= '0;
          end
          OP_STOP: if (ok) begin
            play_r[trk_idx]   <= 1'b0;
            time_tab[trk_idx] <= '0;
          end
          OP_PAUSE:  if (ok) play_r[trk_idx] <= 1'b0;
          OP_RESUME: if (ok) play_r[trk_idx] <= 1'b1;
          OP_SEEK: if (ok) begin
            time_tab[trk_idx] <= (rd_dur == '0) ? 32'sd0 : seek_r;
          end
          OP_LOOP:   if (ok) loop_r[trk_idx] <= lf_r;
          OP_SPEED:  if (ok) speed_tab[trk_idx] <= spd_r;
          OP_GSPEED: gspeed_r <= spd_r;
          OP_DUR:    if (ok) dur_tab[trk_idx] <= dur_r;
          OP_RESET: begin
            for (int i = 0; i < TRACKS; i++) begin
              time_tab[i]  <= '0;
              speed_tab[i] <= SPEED_ONE;
            end
            play_r   <= '0;
            loop_r   <= '0;
            gspeed_r <= SPEED_ONE;
          end
          default: ;
        endcase
      end
      if (cmd.seek_wb) begin
        time_tab[trk_idx] <= seek_time;
      end
      if (cmd.tick_wb) begin
        time_tab[idx_r] <= tick_time;
        if (tick_end) begin
          play_r[idx_r] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.cap) begin
      op_r    <= in_op;
      trk_r   <= in_data[3:0];
      dt_r    <= in_data[23:4];
      seek_r  <= in_data[55:24];
      spd_r   <= in_data[71:56];
      dur_r   <= in_data[102:72];
      lf_r    <= in_data[103];
      idx_r   <= '0;
      ended_r <= '0;
    end
    if (cmd.idx_inc) begin
      idx_r <= idx_r + TW'(1);
    end
    if (cmd.tick_wb && tick_end) begin
      ended_r <= ended_r | (16'd1 << idx_r);
    end
    if (cmd.mul1) begin
      mul1_r <= dt_r * smag;
      neg_r  <= rd_speed[15] ^ gspeed_r[15];
    end
    if (cmd.mul2) begin
      mul2_r <= mul1_r * gmag;
    end
    if (cmd.sum) begin
      sum_r <= {rd_time[31], rd_time} + {step[31], step};
    end
    if (cmd.resp_load) begin
      if (ok) begin
        res_r <= {ended_r, rd_speed, loop_r[trk_idx], play_r[trk_idx], rd_time};
      end else begin
        res_r <= {ended_r, 50'd0};
      end
    end
  end

  assign sts.is_tick  = (op_r == OP_TICK);
  assign sts.seek_div = (op_r == OP_SEEK) && ok && (rd_dur != '0) && (seek_gt || seek_neg);
  assign sts.playing  = play_r[idx_r];
  assign sts.loop_div = loop_r[idx_r] && (rd_dur != '0);
  assign sts.idx_last = (idx_r == TW'(TRACKS - 1));
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = {6'd0, res_r};

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("remainder unit started while busy");
  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_busy)
    else $error("remainder done while busy");

endmodule

// ===== sv/atct_ctrl.sv =====
// Controller: sequences decode, the per-track tick walk and the result hand-off.
module atct_ctrl
  import atct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_tick) begin
          state_nxt = S_T_LOAD;
        end else if (sts.seek_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_SEEK_DIV;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_RESP;
        end
      end
      S_T_LOAD: begin
        cmd.walk = 1'b1;
        if (sts.playing) begin
          state_nxt = S_T_MUL1;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = sts.idx_last ? S_RESP : S_T_LOAD;
        end
      end
      S_T_MUL1: begin
        cmd.walk  = 1'b1;
        cmd.mul1  = 1'b1;
        state_nxt = S_T_MUL2;
      end
      S_T_MUL2: begin
        cmd.walk  = 1'b1;
        cmd.mul2  = 1'b1;
        state_nxt = S_T_SUM;
      end
      S_T_SUM: begin
        cmd.walk  = 1'b1;
        cmd.sum   = 1'b1;
        state_nxt = S_T_DIV;
      end
      S_T_DIV: begin
        // start the remainder from the registered sum when the track loops
        cmd.walk = 1'b1;
        if (sts.loop_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_T_WB;
        end else begin
          state_nxt = S_T_WB;
        end
      end
      S_T_WB: begin
        cmd.walk = 1'b1;
        if (!sts.loop_div || sts.div_done) begin
          cmd.tick_wb = 1'b1;
          cmd.idx_inc = 1'b1;
          state_nxt   = sts.idx_last ? S_RESP : S_T_LOAD;
        end
      end
      S_SEEK_DIV: begin
        if (sts.div_done) begin
          cmd.seek_wb = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> (state_r == S_DECODE))
    else $error("accepted beat not decoded");
  a_resp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |=> (state_r == S_IDLE))
    else $error("no return to idle after result");
  a_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_wb |-> (state_r == S_T_WB) && (!sts.loop_div || sts.div_done))
    else $error("tick write-back before remainder ready");

endmodule

// ===== sv/animation_track_clock_table.sv =====
// Top level of the animation track clock table.
// Usage:
//   Each input beat carries one op on in_tuser and its operands on in_tdata;
//   every op returns exactly one result beat describing the addressed track.
//   Ops other than tick and wrapping seeks are applied in decode and load their
//   result into the output register from the result state. A seek that must
//   wrap runs the remainder unit between decode and the result state.
//   A tick walks all TRACKS tracks in turn: a stopped track visits the load
//   state only, a playing one the load, two multiply, sum, divide and write-back
//   states, and a playing looping one also waits for the one bit-per-cycle
//   remainder unit shared by all tracks.
//   One op is worked on at a time; in_tready is high only between ops.
//   The result register holds a beat until out_tready; a new op is accepted
//   meanwhile, and the controller holds its result back until the register frees.
//   Reset clears all times, playing and looping bits and durations, and sets
//   every speed and the global speed to 1.0; no result is pending after it.
module animation_track_clock_table
  import atct_pkg::*;
#(
  parameter int TRACKS = 16
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // track, delta_time, seek_time, speed_value,
                                  // duration_value, loop_flag
  input  logic [3:0]   in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata  // time_out, playing_out, looping_out, speed_out,
                                  // ended_mask, zero pad
);

  cmd_t    cmd;
  status_t sts;

  atct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atct_dp #(
    .TRACKS (TRACKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule
